/* sv/integer_to_ascii_formatter_defines.svh */
// assertion macros for the integer to ascii formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// checked only while out of reset
`define I2A_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("i2a check failed");

// checked on every edge, reset included
`define I2A_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("i2a check failed");

`endif

/* sv/i2a_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package i2a_pkg;

  typedef enum logic [2:0] {
    FN_CHAR,
    FN_S16,
    FN_U16,
    FN_S32,
    FN_U32,
    FN_HEX16,
    FN_HEX8,
    FN_NONE
  } func_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_CHAR,
    OP_HEX,
    OP_MINUS,
    OP_SKIP,
    OP_TRY,
    OP_DIGIT
  } op_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_SKIP,
    J_MORE,
    J_DISPATCH
  } jmp_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // program addresses
  localparam upc_t S_IDLE   = 4'd0;
  localparam upc_t S_CHAR   = 4'd1;
  localparam upc_t S_HEX    = 4'd2;
  localparam upc_t S_IDLE_H = 4'd3;
  localparam upc_t S_NEG    = 4'd4;
  localparam upc_t S_SKIP   = 4'd5;
  localparam upc_t S_TRY3   = 4'd6;
  localparam upc_t S_TRY2   = 4'd7;
  localparam upc_t S_TRY1   = 4'd8;
  localparam upc_t S_TRY0   = 4'd9;
  localparam upc_t S_DIG    = 4'd10;
  localparam upc_t S_IDLE_D = 4'd11;

  localparam logic [3:0] K_U32   = 4'd0;
  localparam logic [3:0] K_U16   = 4'd5;
  localparam logic [3:0] K_HEX16 = 4'd6;
  localparam logic [3:0] K_HEX8  = 4'd8;
  localparam logic [3:0] LAST_K  = 4'd9;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    op_t        op;
    logic       emit;
    logic [1:0] sh;
    jmp_t       jmp;
    upc_t       tgt;
  } ctl_t;

  typedef struct packed {
    logic more;    // another digit follows this one
    logic skip;    // leading weight still above the magnitude
    logic neg_in;  // incoming signed operand is negative
  } sts_t;

  function automatic ctl_t ucode(upc_t a);
    ctl_t c;
    c = '{op: OP_LOAD, emit: 1'b0, sh: 2'd0, jmp: J_DISPATCH, tgt: S_IDLE};
    case (a)
      S_IDLE:   c = '{op: OP_LOAD,  emit: 1'b0, sh: 2'd0, jmp: J_DISPATCH, tgt: S_IDLE};
      S_CHAR:   c = '{op: OP_CHAR,  emit: 1'b1, sh: 2'd0, jmp: J_ALWAYS,   tgt: S_IDLE};
      S_HEX:    c = '{op: OP_HEX,   emit: 1'b1, sh: 2'd0, jmp: J_MORE,     tgt: S_HEX};
      S_IDLE_H: c = '{op: OP_LOAD,  emit: 1'b0, sh: 2'd0, jmp: J_DISPATCH, tgt: S_IDLE};
      S_NEG:    c = '{op: OP_MINUS, emit: 1'b1, sh: 2'd0, jmp: J_NEXT,     tgt: S_IDLE};
      S_SKIP:   c = '{op: OP_SKIP,  emit: 1'b0, sh: 2'd0, jmp: J_SKIP,     tgt: S_SKIP};
      S_TRY3:   c = '{op: OP_TRY,   emit: 1'b0, sh: 2'd3, jmp: J_NEXT,     tgt: S_IDLE};
      S_TRY2:   c = '{op: OP_TRY,   emit: 1'b0, sh: 2'd2, jmp: J_NEXT,     tgt: S_IDLE};
      S_TRY1:   c = '{op: OP_TRY,   emit: 1'b0, sh: 2'd1, jmp: J_NEXT,     tgt: S_IDLE};
      S_TRY0:   c = '{op: OP_TRY,   emit: 1'b0, sh: 2'd0, jmp: J_NEXT,     tgt: S_IDLE};
      S_DIG:    c = '{op: OP_DIGIT, emit: 1'b1, sh: 2'd0, jmp: J_MORE,     tgt: S_TRY3};
      S_IDLE_D: c = '{op: OP_LOAD,  emit: 1'b0, sh: 2'd0, jmp: J_DISPATCH, tgt: S_IDLE};
      default:  c = '{op: OP_LOAD,  emit: 1'b0, sh: 2'd0, jmp: J_DISPATCH, tgt: S_IDLE};
    endcase
    return c;
  endfunction

  function automatic upc_t entry(func_t f, logic neg);
    upc_t e;
    case (f)
      FN_CHAR:  e = S_CHAR;
      FN_S16:   e = neg ? S_NEG : S_SKIP;
      FN_U16:   e = S_SKIP;
      FN_S32:   e = neg ? S_NEG : S_SKIP;
      FN_U32:   e = S_SKIP;
      FN_HEX16: e = S_HEX;
      FN_HEX8:  e = S_HEX;
      default:  e = S_IDLE;
    endcase
    return e;
  endfunction

  function automatic logic [31:0] dec_weight(logic [3:0] k);
    logic [31:0] w;
    case (k)
      4'd0:    w = 32'd1000000000;
      4'd1:    w = 32'd100000000;
      4'd2:    w = 32'd10000000;
      4'd3:    w = 32'd1000000;
      4'd4:    w = 32'd100000;
      4'd5:    w = 32'd10000;
      4'd6:    w = 32'd1000;
      4'd7:    w = 32'd100;
      4'd8:    w = 32'd10;
      default: w = 32'd1;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = CH_ZERO + {4'b0, n};
    end else begin
      c = CH_A + {4'b0, n - 4'd10};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/i2a_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] value;
  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;
  modport source (output valid, output char_out, output last, input ready);
  modport sink (input valid, input char_out, input last, output ready);
endinterface
`default_nettype wire

/* sv/i2a_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
module i2a_sequencer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  input  i2a_pkg::func_t func,
  input  i2a_pkg::sts_t sts,
  output i2a_pkg::ctl_t ctl,
  output logic          adv,
  output logic          in_ready
);
  import i2a_pkg::*;

  upc_t upc_r;
  upc_t upc_nxt;
  upc_t upc_inc;
  logic hold;

  assign ctl      = ucode(upc_r);
  assign in_ready = (ctl.op == OP_LOAD);
  assign hold     = (ctl.emit && !out_free) || ((ctl.op == OP_LOAD) && !in_valid);
  assign adv      = !hold;
  assign upc_inc  = upc_r + upc_t'(1);

  always_comb begin
    upc_nxt = upc_r;
    if (!hold) begin
      case (ctl.jmp)
        J_NEXT:     upc_nxt = upc_inc;
        J_ALWAYS:   upc_nxt = ctl.tgt;
        J_SKIP:     upc_nxt = sts.skip ? ctl.tgt : upc_inc;
        J_MORE:     upc_nxt = sts.more ? ctl.tgt : upc_inc;
        J_DISPATCH: upc_nxt = entry(func, sts.neg_in);
        default:    upc_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/i2a_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module i2a_datapath (
  input  logic           clk,
  input  i2a_pkg::ctl_t  ctl,
  input  logic           adv,
  input  i2a_pkg::func_t func,
  input  logic [31:0]    value,
  output i2a_pkg::sts_t  sts,
  output logic [7:0]     ch,
  output logic           ch_last
);
  import i2a_pkg::*;

  logic [31:0] mag_r;
  logic [31:0] mag_nxt;
  logic [3:0]  k_r;
  logic [3:0]  k_nxt;
  logic [3:0]  dig_r;
  logic [3:0]  dig_nxt;
  logic [31:0] w;
  logic [33:0] w_sh;
  logic        ge;
  logic [15:0] low16;
  logic [15:0] neg16;
  logic [31:0] neg32;

  assign low16 = value[15:0];
  assign neg16 = 16'd0 - low16;
  assign neg32 = 32'd0 - value;
  assign w     = dec_weight(k_r);
  assign w_sh  = {2'b0, w} << ctl.sh;
  assign ge    = ({2'b0, mag_r} >= w_sh);

  assign sts.more   = (k_r != LAST_K);
  assign sts.skip   = (k_r < LAST_K) && (mag_r < w);
  assign sts.neg_in = ((func == FN_S16) && value[15]) || ((func == FN_S32) && value[31]);

  always_comb begin
    mag_nxt = mag_r;
    k_nxt   = k_r;
    dig_nxt = dig_r;
    case (ctl.op)
      OP_LOAD: begin
        dig_nxt = 4'd0;
        case (func)
          FN_S16:   begin mag_nxt = {16'b0, sts.neg_in ? neg16 : low16}; k_nxt = K_U16; end
          FN_U16:   begin mag_nxt = {16'b0, low16}; k_nxt = K_U16; end
          FN_S32:   begin mag_nxt = sts.neg_in ? neg32 : value; k_nxt = K_U32; end
          FN_U32:   begin mag_nxt = value; k_nxt = K_U32; end
          FN_HEX16: begin mag_nxt = {low16, 16'b0}; k_nxt = K_HEX16; end
          FN_HEX8:  begin mag_nxt = {value[7:0], 24'b0}; k_nxt = K_HEX8; end
          default:  begin mag_nxt = value; k_nxt = K_U32; end
        endcase
      end
      OP_HEX: begin
        mag_nxt = {mag_r[27:0], 4'b0};
        k_nxt   = k_r + 4'd1;
      end
      OP_SKIP: begin
        if (sts.skip) begin
          k_nxt = k_r + 4'd1;
        end
      end
      OP_TRY: begin
        // restoring step against weight times 8, 4, 2, 1
        if (ge) begin
          mag_nxt        = mag_r - w_sh[31:0];
          dig_nxt[ctl.sh] = 1'b1;
        end
      end
      OP_DIGIT: begin
        k_nxt   = k_r + 4'd1;
        dig_nxt = 4'd0;
      end
      default: begin
        mag_nxt = mag_r;
      end
    endcase
  end

  always_comb begin
    ch      = CH_ZERO;
    ch_last = 1'b0;
    case (ctl.op)
      OP_CHAR:  begin ch = mag_r[7:0]; ch_last = 1'b1; end
      OP_HEX:   begin ch = hex_char(mag_r[31:28]); ch_last = !sts.more; end
      OP_MINUS: begin ch = CH_MINUS; ch_last = 1'b0; end
      OP_DIGIT: begin ch = CH_ZERO + {4'b0, dig_r}; ch_last = !sts.more; end
      default:  begin ch = CH_ZERO; ch_last = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r <= mag_nxt;
      k_r   <= k_nxt;
      dig_r <= dig_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/integer_to_ascii_formatter.sv */
// first character for raw, hex and '-' is emitted by the step after the load step, then registered
// decimal first runs a skip step per leading weight above the magnitude and one more, then per digit
// the trial steps against weight times 8, 4, 2 and 1 and a digit step; the '-' step comes first
// one request in work at a time: a new request is taken only in a load step, after the last character
// reset: synchronous, returns the step counter to idle and empties the output register
`timescale 1ns / 1ps
`default_nettype none
module integer_to_ascii_formatter (
  input logic          clk,
  input logic          rst_n,
  i2a_in_if.sink       in_ch,
  i2a_out_if.source    out_ch
);
  import i2a_pkg::*;

  ctl_t       ctl;
  sts_t       sts;
  logic       adv;
  logic       in_ready;
  logic       out_free;
  logic [7:0] ch;
  logic       ch_last;
  func_t      func;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_last_r;

  assign func     = func_t'(in_ch.func);
  assign out_free = !out_valid_r || out_ch.ready;

  i2a_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .func     (func),
    .sts      (sts),
    .ctl      (ctl),
    .adv      (adv),
    .in_ready (in_ready)
  );

  i2a_datapath u_dp (
    .clk     (clk),
    .ctl     (ctl),
    .adv     (adv),
    .func    (func),
    .value   (in_ch.value),
    .sts     (sts),
    .ch      (ch),
    .ch_last (ch_last)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv && ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl.emit) begin
      out_char_r <= ch;
      out_last_r <= ch_last;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last     = out_last_r;

endmodule
`default_nettype wire

/* sv/i2a_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"
module i2a_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);
  import i2a_pkg::*;

  // a stalled result holds
  `I2A_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))

  // one request at a time: anything that prints closes the input
  `I2A_ASSERT(a_busy_after_req, clk, rst_n, in_valid && in_ready && (in_func != FN_NONE) |=> !in_ready)

  // only digits, hex letters and the sign come before the final character
  `I2A_ASSERT(a_mid_char, clk, rst_n, out_valid && !out_last |-> ((out_char >= CH_ZERO) && (out_char <= CH_NINE)) || ((out_char >= CH_A) && (out_char <= CH_F)) || (out_char == CH_MINUS))

  `I2A_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.char_out),
  .out_last  (out_ch.last)
);
`default_nettype wire

/* dv/tb_integer_to_ascii_formatter.sv */
`timescale 1ns / 1ps
module tb_integer_to_ascii_formatter;
  import i2a_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ascii_char_t;

  localparam logic [7:0] HEX_GLYPH [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };
  localparam logic [7:0] GLYPH_ZERO  = 8'h30;
  localparam logic [7:0] GLYPH_MINUS = 8'h2D;
  localparam int SETTLE_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n;

  i2a_in_if  in_bus ();
  i2a_out_if out_bus ();

  integer_to_ascii_formatter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  ascii_char_t expected_chars[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // append the decimal digits of a magnitude, most significant first
  function automatic void push_decimal(logic [31:0] mag);
    logic [7:0] digits[$];
    logic [31:0] rest;
    rest = mag;
    do begin
      digits.push_front(GLYPH_ZERO + 8'(rest % 32'd10));
      rest = rest / 32'd10;
    end while (rest != 32'd0);
    foreach (digits[i]) expected_chars.push_back('{ch: digits[i], last: 1'b0});
  endfunction

  function automatic void format_ascii(func_t kind, logic [31:0] operand);
    int          first_new;
    logic [15:0] low16;
    first_new = expected_chars.size();
    low16 = operand[15:0];
    case (kind)
      FN_CHAR: expected_chars.push_back('{ch: operand[7:0], last: 1'b0});
      FN_S16: begin
        if (low16[15]) begin
          expected_chars.push_back('{ch: GLYPH_MINUS, last: 1'b0});
          push_decimal({16'h0, 16'(-low16)});
        end else begin
          push_decimal({16'h0, low16});
        end
      end
      FN_U16: push_decimal({16'h0, low16});
      FN_S32: begin
        if (operand[31]) begin
          expected_chars.push_back('{ch: GLYPH_MINUS, last: 1'b0});
          push_decimal(-operand);
        end else begin
          push_decimal(operand);
        end
      end
      FN_U32: push_decimal(operand);
      FN_HEX16: begin
        for (int s = 12; s >= 0; s -= 4) begin
          expected_chars.push_back('{ch: HEX_GLYPH[(low16 >> s) & 16'hF], last: 1'b0});
        end
      end
      FN_HEX8: begin
        expected_chars.push_back('{ch: HEX_GLYPH[operand[7:4]], last: 1'b0});
        expected_chars.push_back('{ch: HEX_GLYPH[operand[3:0]], last: 1'b0});
      end
      default: ;
    endcase
    if (expected_chars.size() > first_new) begin
      expected_chars[expected_chars.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    ascii_char_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected char_out %h last %b", out_bus.char_out, out_bus.last);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_bus.char_out !== want.ch) begin
          $error("char_out expected %h actual %h", want.ch, out_bus.char_out);
          mismatches++;
        end
        if (out_bus.last !== want.last) begin
          $error("last expected %b actual %b", want.last, out_bus.last);
          mismatches++;
        end
      end
    end
  end

  task automatic send_request(func_t kind, logic [31:0] operand);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.func  <= kind;
    in_bus.value <= operand;
    do @(posedge clk); while (!in_bus.ready);
    format_ascii(kind, operand);
  endtask

  // hold off until every character is out, then let the digit loop settle
  task automatic wait_for_idle();
    in_bus.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] r;
    case ($urandom_range(0, 4))
      0: r = $urandom;
      1: r = $urandom_range(0, 9);
      2: r = $urandom >> $urandom_range(0, 31);
      3: r = -($urandom >> $urandom_range(0, 31));
      default: begin
        r = $urandom;
        r[15] = 1'b1;
        r[14:0] = r[14:0] >> $urandom_range(0, 14);
      end
    endcase
    return r;
  endfunction

  task automatic test_char();
    send_request(FN_CHAR, 32'h0000_0000);
    send_request(FN_CHAR, 32'hFFFF_FF41);
    send_request(FN_CHAR, 32'h0000_00FF);
  endtask

  task automatic test_decimal_16();
    send_request(FN_S16, 32'h0000_8000);
    send_request(FN_S16, 32'h0000_7FFF);
    send_request(FN_S16, 32'hFFFF_FFFF);
    send_request(FN_S16, 32'h0000_0000);
    send_request(FN_S16, 32'hABCD_0005);
    send_request(FN_U16, 32'h0000_0000);
    send_request(FN_U16, 32'hFFFF_FFFF);
    send_request(FN_U16, 32'd10000);
  endtask

  task automatic test_decimal_32();
    send_request(FN_S32, 32'h8000_0000);
    send_request(FN_S32, 32'h7FFF_FFFF);
    send_request(FN_S32, 32'hFFFF_FFFF);
    send_request(FN_S32, 32'h0000_0000);
    send_request(FN_U32, 32'hFFFF_FFFF);
    send_request(FN_U32, 32'd1000000000);
    send_request(FN_U32, 32'd9);
  endtask

  task automatic test_hex();
    send_request(FN_HEX16, 32'h0000_0000);
    send_request(FN_HEX16, 32'h1234_ABCD);
    send_request(FN_HEX8, 32'h0000_0000);
    send_request(FN_HEX8, 32'hFFFF_FF9E);
  endtask

  // kind 7 yields nothing; the request after it must still format normally
  task automatic test_unused_kind();
    send_request(FN_NONE, 32'hFFFF_FFFF);
    send_request(FN_CHAR, 32'h0000_005A);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall, int count);
    func_t kind;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    for (int n = 0; n < count; ) begin
      // the unused kind shows up now and then but does not count
      if ($urandom_range(0, 19) == 0) begin
        kind = FN_NONE;
      end else begin
        kind = func_t'($urandom_range(0, 6));
        n++;
      end
      send_request(kind, rand_operand());
    end
    wait_for_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.func = FN_CHAR;
    in_bus.value = 32'h0;
    out_bus.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_char();
    test_decimal_16();
    test_decimal_32();
    test_hex();
    test_unused_kind();
    wait_for_idle();
    test_random_traffic(0, 0, 72);
    test_random_traffic(70, 0, 72);
    test_random_traffic(0, 70, 72);
    test_random_traffic(18, 18, 72);
    if (mismatches == 0) begin
      $display("[integer_to_ascii_formatter] OK");
    end else begin
      $display("[integer_to_ascii_formatter] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[integer_to_ascii_formatter] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/i2a_pkg.sv
sv/i2a_if.sv
sv/i2a_sequencer.sv
sv/i2a_datapath.sv
sv/integer_to_ascii_formatter.sv
sv/i2a_checker.sv
dv/tb_integer_to_ascii_formatter.sv
